// ----- rtl/core/ctc_pkg.sv -----
// Package for the chunked transfer CRC-32 checker.
// Holds action and event codes, the item and result structs and the CRC byte update.
// No dependencies.
package ctc_pkg;

  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_HEADER = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_STATUS = 3'd3,
    ACT_CANCEL = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_READY      = 3'd1,
    EV_ERROR      = 3'd2,
    EV_PERMISSION = 3'd3,
    EV_NOT_FOUND  = 3'd4
  } event_t;

  localparam logic [7:0]  STATUS_PERMISSION = 8'd1;
  localparam logic [7:0]  STATUS_NOT_FOUND  = 8'd2;
  localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_LENGTH        = 32'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] generation;
    logic [31:0] object_size;
    logic [31:0] expected_crc;
    logic [31:0] packet_offset;
    logic [15:0] packet_length;
    logic [7:0]  data_byte;
    logic [7:0]  status_code;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        receiving;
    logic [31:0] revision_out;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/ctc_in_stage.sv -----
// Input register for the chunked transfer CRC-32 checker.
// Holds one accepted transfer until the engine consumes it. Uses ctc_pkg.
module ctc_in_stage
  import ctc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_in,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid_q;
  item_t item_q;

  assign in_ready   = !valid_q || take;
  assign held_valid = valid_q;
  assign held_item  = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

endmodule

// ----- rtl/core/ctc_engine.sv -----
// Transfer state and per-item decision logic for the chunked transfer checker.
// Updates state and forms one result per consumed transfer. Uses ctc_pkg.
module ctc_engine
  import ctc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1048576
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  output result_t result
);

  localparam int BW = $clog2(MAX_BYTES + 1);

  logic          open_flag, open_flag_next;
  logic [15:0]   active_generation, active_generation_next;
  logic [BW-1:0] bytes_expected, bytes_expected_next;
  logic [BW-1:0] bytes_received, bytes_received_next;
  logic [31:0]   crc_target, crc_target_next;
  logic [31:0]   crc_running, crc_running_next;
  logic [15:0]   packet_left, packet_left_next;
  logic [31:0]   revision_count, revision_count_next;
  event_t        ev;

  logic [31:0]   crc_new;
  logic [BW-1:0] received_inc;
  logic [31:0]   revision_inc;
  logic [32:0]   packet_end;
  logic          begin_bad;
  logic          header_bad;

  assign crc_new      = crc_byte(crc_running, item.data_byte);
  assign received_inc = bytes_received + BW'(1);
  assign revision_inc = revision_count + 32'd1;
  assign packet_end   = {1'b0, item.packet_offset} + {17'd0, item.packet_length};
  assign begin_bad    = (item.generation == 16'd0) || (item.object_size < MIN_LENGTH) ||
                        (item.object_size > 32'(MAX_BYTES));
  assign header_bad   = !open_flag || (packet_left != 16'd0) ||
                        (item.packet_length == 16'd0) ||
                        (item.generation != active_generation) ||
                        (item.packet_offset != 32'(bytes_received)) ||
                        (packet_end > 33'(bytes_expected));

  always_comb begin
    open_flag_next         = open_flag;
    active_generation_next = active_generation;
    bytes_expected_next    = bytes_expected;
    bytes_received_next    = bytes_received;
    crc_target_next        = crc_target;
    crc_running_next       = crc_running;
    packet_left_next       = packet_left;
    revision_count_next    = revision_count;
    ev                     = EV_NONE;
    case (action_t'(item.action))
      ACT_BEGIN: begin
        if (begin_bad) begin
          ev = EV_ERROR;
        end else begin
          open_flag_next         = 1'b1;
          active_generation_next = item.generation;
          bytes_expected_next    = item.object_size[BW-1:0];
          bytes_received_next    = '0;
          crc_target_next        = item.expected_crc;
          crc_running_next       = CRC_INIT;
          packet_left_next       = 16'd0;
        end
      end
      ACT_HEADER: begin
        if (header_bad) begin
          open_flag_next         = 1'b0;
          active_generation_next = 16'd0;
          bytes_expected_next    = '0;
          bytes_received_next    = '0;
          crc_target_next        = 32'd0;
          crc_running_next       = CRC_INIT;
          packet_left_next       = 16'd0;
          ev                     = EV_ERROR;
        end else begin
          packet_left_next = item.packet_length;
        end
      end
      ACT_DATA: begin
        if (!open_flag || packet_left == 16'd0 || received_inc == bytes_expected) begin
          open_flag_next         = 1'b0;
          active_generation_next = 16'd0;
          bytes_expected_next    = '0;
          bytes_received_next    = '0;
          crc_target_next        = 32'd0;
          crc_running_next       = CRC_INIT;
          packet_left_next       = 16'd0;
          ev                     = EV_ERROR;
          if (open_flag && packet_left != 16'd0 && ~crc_new == crc_target) begin
            revision_count_next = (revision_inc == 32'd0) ? 32'd1 : revision_inc;
            ev                  = EV_READY;
          end
        end else begin
          crc_running_next    = crc_new;
          bytes_received_next = received_inc;
          packet_left_next    = packet_left - 16'd1;
        end
      end
      ACT_STATUS, ACT_CANCEL: begin
        open_flag_next         = 1'b0;
        active_generation_next = 16'd0;
        bytes_expected_next    = '0;
        bytes_received_next    = '0;
        crc_target_next        = 32'd0;
        crc_running_next       = CRC_INIT;
        packet_left_next       = 16'd0;
        if (action_t'(item.action) == ACT_STATUS) begin
          if (item.status_code == STATUS_PERMISSION) begin
            ev = EV_PERMISSION;
          end else if (item.status_code == STATUS_NOT_FOUND) begin
            ev = EV_NOT_FOUND;
          end else begin
            ev = EV_ERROR;
          end
        end
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
  end

  assign result.event_res    = ev;
  assign result.receiving    = open_flag_next;
  assign result.revision_out = revision_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag         <= 1'b0;
      active_generation <= 16'd0;
      bytes_expected    <= '0;
      bytes_received    <= '0;
      crc_target        <= 32'd0;
      crc_running       <= CRC_INIT;
      packet_left       <= 16'd0;
      revision_count    <= 32'd0;
    end else if (go) begin
      open_flag         <= open_flag_next;
      active_generation <= active_generation_next;
      bytes_expected    <= bytes_expected_next;
      bytes_received    <= bytes_received_next;
      crc_target        <= crc_target_next;
      crc_running       <= crc_running_next;
      packet_left       <= packet_left_next;
      revision_count    <= revision_count_next;
    end
  end

  a_left_needs_open: assert property (@(posedge clk) disable iff (rst)
    (packet_left != 16'd0) |-> open_flag)
    else $error("packet bytes due with no open transfer");

  a_received_bound: assert property (@(posedge clk) disable iff (rst)
    open_flag |-> (bytes_received < bytes_expected))
    else $error("received count reached expected length while open");

  a_closed_clean: assert property (@(posedge clk) disable iff (rst)
    !open_flag |-> (bytes_received == '0 && crc_running == CRC_INIT))
    else $error("closed transfer left stale progress");

  a_cancel_closes: assert property (@(posedge clk) disable iff (rst)
    (go && action_t'(item.action) == ACT_CANCEL) |=> !open_flag)
    else $error("cancel did not close the transfer");

endmodule

// ----- rtl/core/ctc_out_stage.sv -----
// Result register for the chunked transfer CRC-32 checker.
// Holds one result until the consumer takes it. Uses ctc_pkg.
module ctc_out_stage
  import ctc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_out
);

  logic    valid_q;
  result_t result_q;

  assign space      = !valid_q || out_ready;
  assign out_valid  = valid_q;
  assign result_out = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (space) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

// ----- rtl/core/chunked_transfer_crc32_checker_top.sv -----
// Top level of the chunked transfer CRC-32 checker.
// Depends on ctc_pkg, ctc_in_stage, ctc_engine and ctc_out_stage.
//
//   channel  handshake            payload
//   input    in_valid / in_ready  action generation object_size expected_crc
//                                 packet_offset packet_length data_byte status_code
//   output   out_valid/out_ready  event_res receiving revision_out
//
// One transfer per cycle sustained while the output is taken; the result leaves from a register.
// The input register feeds the engine, which updates state and fills the result register.
// rst clears valid flags and transfer state; revision count restarts at 0.
// A stalled output holds the result and the engine; the input register takes one more.
module chunked_transfer_crc32_checker_top
  import ctc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] generation,
  input  logic [31:0] object_size,
  input  logic [31:0] expected_crc,
  input  logic [31:0] packet_offset,
  input  logic [15:0] packet_length,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  status_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic        receiving,
  output logic [31:0] revision_out
);

  item_t   item_in;
  item_t   held_item;
  logic    held_valid;
  logic    space;
  logic    go;
  result_t result_next;
  result_t result_q;

  assign item_in.action        = action;
  assign item_in.generation    = generation;
  assign item_in.object_size   = object_size;
  assign item_in.expected_crc  = expected_crc;
  assign item_in.packet_offset = packet_offset;
  assign item_in.packet_length = packet_length;
  assign item_in.data_byte     = data_byte;
  assign item_in.status_code   = status_code;

  assign go = held_valid && space;

  ctc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_in   (item_in),
    .take      (go),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  ctc_engine #(
    .MAX_BYTES(MAX_BYTES)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .item  (held_item),
    .result(result_next)
  );

  ctc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .result_in (result_next),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_out(result_q)
  );

  assign event_res    = result_q.event_res;
  assign receiving    = result_q.receiving;
  assign revision_out = result_q.revision_out;

endmodule

// ----- tb/ctc_tb_pkg.sv -----
// Shared testbench helpers for the chunked transfer CRC-32 checker.
// Holds the bitwise CRC-32 update and the spare action codes; depends on ctc_pkg.
package ctc_tb_pkg;
  import ctc_pkg::*;

  localparam logic [31:0] OBJ_MAX         = 32'd1048576;
  localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;

  function automatic logic [31:0] crc32_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

endpackage

// ----- tb/ctc_result_checker.sv -----
// Transfer monitor and result checker for the chunked transfer CRC-32 checker.
// Tracks the receiver state per accepted input transfer and compares each output transfer.
// Depends on ctc_pkg and ctc_tb_pkg.
module ctc_result_checker
  import ctc_pkg::*;
  import ctc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] generation,
  input  logic [31:0] object_size,
  input  logic [31:0] expected_crc,
  input  logic [31:0] packet_offset,
  input  logic [15:0] packet_length,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  status_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  event_res,
  input  logic        receiving,
  input  logic [31:0] revision_out,
  output int          mismatches,
  output int          reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        is_open;
  logic [15:0] cur_gen;
  logic [20:0] need_bytes;
  logic [20:0] got_bytes;
  logic [31:0] crc_goal;
  logic [31:0] crc_acc;
  logic [15:0] pkt_left;
  logic [31:0] revision;
  result_t     report_q[$];

  function automatic void drop_transfer();
    is_open    = 1'b0;
    cur_gen    = '0;
    need_bytes = '0;
    got_bytes  = '0;
    crc_goal   = '0;
    crc_acc    = CRC_INIT;
    pkt_left   = '0;
  endfunction

  function automatic result_t advance_receiver(input item_t it);
    event_t      ev;
    logic [32:0] pkt_end;
    ev      = EV_NONE;
    pkt_end = {1'b0, it.packet_offset} + {17'd0, it.packet_length};
    case (it.action)
      ACT_BEGIN: begin
        if (it.generation == '0 || it.object_size < MIN_LENGTH || it.object_size > OBJ_MAX) begin
          ev = EV_ERROR;
        end else begin
          drop_transfer();
          is_open    = 1'b1;
          cur_gen    = it.generation;
          need_bytes = it.object_size[20:0];
          crc_goal   = it.expected_crc;
        end
      end
      ACT_HEADER: begin
        if (!is_open || pkt_left != '0 || it.packet_length == '0 ||
            it.generation != cur_gen || it.packet_offset != {11'd0, got_bytes} ||
            pkt_end > {12'd0, need_bytes}) begin
          drop_transfer();
          ev = EV_ERROR;
        end else begin
          pkt_left = it.packet_length;
        end
      end
      ACT_DATA: begin
        if (!is_open || pkt_left == '0) begin
          drop_transfer();
          ev = EV_ERROR;
        end else begin
          crc_acc   = crc32_feed(crc_acc, it.data_byte);
          got_bytes = got_bytes + 21'd1;
          pkt_left  = pkt_left - 16'd1;
          if (got_bytes == need_bytes) begin
            if ((crc_acc ^ CRC_INIT) == crc_goal) begin
              revision = revision + 32'd1;
              if (revision == '0) revision = 32'd1;
              ev = EV_READY;
            end else begin
              ev = EV_ERROR;
            end
            drop_transfer();
          end
        end
      end
      ACT_STATUS: begin
        drop_transfer();
        if (it.status_code == STATUS_PERMISSION) ev = EV_PERMISSION;
        else if (it.status_code == STATUS_NOT_FOUND) ev = EV_NOT_FOUND;
        else ev = EV_ERROR;
      end
      ACT_CANCEL: begin
        drop_transfer();
      end
      default: ;
    endcase
    return '{event_res: ev, receiving: is_open, revision_out: revision};
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      drop_transfer();
      revision = '0;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{event_res, receiving, revision_out};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ev %0d rx %0b rev %0d", $time,
                     got.event_res, got.receiving, got.revision_out);
        end else begin
          want = report_q.pop_front();
          if (got.event_res !== want.event_res || got.receiving !== want.receiving ||
              got.revision_out !== want.revision_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected ev %0d rx %0b rev %0d, got ev %0d rx %0b rev %0d",
                       $time, want.event_res, want.receiving, want.revision_out,
                       got.event_res, got.receiving, got.revision_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        it = '{action, generation, object_size, expected_crc, packet_offset,
               packet_length, data_byte, status_code};
        report_q.push_back(advance_receiver(it));
      end
    end
    reports_owed <= report_q.size();
  end

endmodule

// ----- tb/chunked_transfer_crc32_checker_top_test.sv -----
// Testbench top for the chunked transfer CRC-32 checker: clock, reset, stimulus and verdict.
// Sends directed and random chunked transfers with random idling on both channels.
// Depends on ctc_pkg, ctc_tb_pkg, ctc_result_checker and the block itself.
module chunked_transfer_crc32_checker_top_test
  import ctc_pkg::*;
  import ctc_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    F_NONE, F_GEN, F_OFFSET, F_EMPTY, F_OVERRUN, F_STRAY, F_NESTED,
    F_STATUS, F_CANCEL, F_BAD_BEGIN, F_REBEGIN, F_SPARE
  } fault_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [15:0] generation;
  logic [31:0] object_size;
  logic [31:0] expected_crc;
  logic [31:0] packet_offset;
  logic [15:0] packet_length;
  logic [7:0]  data_byte;
  logic [7:0]  status_code;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  event_res;
  logic        receiving;
  logic [31:0] revision_out;
  int          mismatches;
  int          reports_owed;
  int          items_sent;
  int          cycles;
  bit          send_calm;
  bit          take_calm;

  chunked_transfer_crc32_checker_top u_top (.*);

  ctc_result_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("chunked_transfer_crc32_checker_top_test failed");
      $finish;
    end
  end

  function automatic item_t make_item(input logic [2:0] act);
    item_t it;
    it.action        = act;
    it.generation    = 16'($urandom_range(0, 65535));
    it.object_size   = $urandom;
    it.expected_crc  = $urandom;
    it.packet_offset = $urandom;
    it.packet_length = 16'($urandom_range(0, 65535));
    it.data_byte     = 8'($urandom_range(0, 255));
    it.status_code   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic push_item(input item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action        <= it.action;
    generation    <= it.generation;
    object_size   <= it.object_size;
    expected_crc  <= it.expected_crc;
    packet_offset <= it.packet_offset;
    packet_length <= it.packet_length;
    data_byte     <= it.data_byte;
    status_code   <= it.status_code;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.action <= ACT_CANCEL) items_sent++;
  endtask

  task automatic send_begin(input logic [15:0] gen, input logic [31:0] total,
                            input logic [31:0] crc);
    item_t it;
    it              = make_item(ACT_BEGIN);
    it.generation   = gen;
    it.object_size  = total;
    it.expected_crc = crc;
    push_item(it);
  endtask

  task automatic send_header(input logic [15:0] gen, input logic [31:0] off,
                             input logic [15:0] len);
    item_t it;
    it               = make_item(ACT_HEADER);
    it.generation    = gen;
    it.packet_offset = off;
    it.packet_length = len;
    push_item(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    item_t it;
    it           = make_item(ACT_DATA);
    it.data_byte = b;
    push_item(it);
  endtask

  task automatic send_status(input logic [7:0] code);
    item_t it;
    it             = make_item(ACT_STATUS);
    it.status_code = code;
    push_item(it);
  endtask

  task automatic run_transfer(input int unsigned len, input bit good, input fault_t fault,
                              input int unsigned fault_pkt);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [31:0] tag;
    logic [15:0] gen;
    int unsigned pos;
    int unsigned pkt;
    int unsigned rest;
    int unsigned chunk;
    tag = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      body.push_back(b);
      tag = crc32_feed(tag, b);
    end
    tag = tag ^ CRC_INIT;
    if (!good) tag = tag ^ (32'd1 << $urandom_range(0, 31));
    gen = 16'($urandom_range(1, 65535));
    send_begin(gen, len, tag);
    pos = 0;
    pkt = 0;
    while (pos < len) begin
      rest  = len - pos;
      chunk = ($urandom_range(0, 3) == 0) ? rest : $urandom_range(1, (rest < 16) ? rest : 16);
      if (pkt == fault_pkt) begin
        case (fault)
          F_GEN: begin
            send_header(gen ^ 16'(1 << $urandom_range(0, 15)), pos, 16'(chunk));
            return;
          end
          F_OFFSET: begin
            send_header(gen, pos ^ (32'd1 << $urandom_range(0, 31)), 16'(chunk));
            return;
          end
          F_EMPTY: begin
            send_header(gen, pos, 16'd0);
            return;
          end
          F_OVERRUN: begin
            send_header(gen, pos, 16'(rest + 1 + $urandom_range(0, 3)));
            return;
          end
          F_STRAY: begin
            send_data(8'($urandom_range(0, 255)));
            return;
          end
          F_NESTED: begin
            send_header(gen, pos, 16'(chunk));
            send_header(gen, pos, 16'(chunk));
            return;
          end
          F_STATUS: begin
            case ($urandom_range(0, 2))
              0: send_status(STATUS_PERMISSION);
              1: send_status(STATUS_NOT_FOUND);
              default: send_status(8'($urandom_range(0, 255)));
            endcase
            return;
          end
          F_CANCEL: begin
            push_item(make_item(ACT_CANCEL));
            return;
          end
          F_BAD_BEGIN: begin
            case ($urandom_range(0, 2))
              0: send_begin(16'd0, $urandom_range(MIN_LENGTH, OBJ_MAX), $urandom);
              1: send_begin(gen, $urandom_range(0, MIN_LENGTH - 1), $urandom);
              default: send_begin(gen, $urandom_range(OBJ_MAX + 1, 32'hFFFF_FFFF), $urandom);
            endcase
          end
          F_REBEGIN: begin
            send_begin(16'($urandom_range(1, 65535)), $urandom_range(MIN_LENGTH, OBJ_MAX),
                       $urandom);
            return;
          end
          F_SPARE: begin
            push_item(make_item(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST))));
          end
          default: ;
        endcase
      end
      send_header(gen, pos, 16'(chunk));
      for (int i = 0; i < chunk; i++) send_data(body[pos + i]);
      pos += chunk;
      pkt++;
    end
  endtask

  initial begin
    int unsigned len;
    fault_t      fault;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_CANCEL;
    generation    <= '0;
    object_size   <= '0;
    expected_crc  <= '0;
    packet_offset <= '0;
    packet_length <= '0;
    data_byte     <= '0;
    status_code   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_data(8'h00);
    send_header(16'h0001, 32'd0, 16'd4);
    send_begin(16'h0000, 32'd16, $urandom);
    send_begin(16'h0001, MIN_LENGTH - 1, $urandom);
    send_begin(16'hFFFF, OBJ_MAX, 32'hFFFF_FFFF);
    send_header(16'hFFFF, 32'd0, 16'hFFFF);
    send_data(8'hFF);
    send_header(16'hFFFF, 32'd1, 16'd1);
    for (int f = F_GEN; f <= F_STRAY; f++) run_transfer(4, 1'b1, fault_t'(f), 0);
    run_transfer(4, 1'b1, F_BAD_BEGIN, 0);
    send_status(STATUS_PERMISSION);
    send_status(STATUS_NOT_FOUND);
    send_status(8'd0);
    push_item(make_item(ACT_CANCEL));
    push_item(make_item(ACT_SPARE_LAST));

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        len   = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 400) : $urandom_range(4, 48);
        fault = ($urandom_range(0, 5) == 0) ? fault_t'($urandom_range(F_GEN, F_SPARE)) : F_NONE;
        run_transfer(len, $urandom_range(0, 4) != 0, fault, $urandom_range(0, 3));
      end else begin
        push_item(make_item(3'($urandom_range(0, 7))));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && reports_owed == 0) begin
      $display("chunked_transfer_crc32_checker_top_test passed");
    end else begin
      $display("chunked_transfer_crc32_checker_top_test failed");
    end
    $finish;
  end

  initial begin
    int hold;
    out_ready <= 1'b0;
    repeat (5) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
      hold = take_calm ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

endmodule
